// ===== hdl/barsc_pkg.sv =====
`default_nettype none

package barsc_pkg;

   // input transaction: one raw sample pair
   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
   } req_type;

   // result transaction
   typedef struct packed {
      logic signed [15:0] temperature_tenths;
      logic [23:0]        pressure_pa;
      logic [1:0]         status;
   } rsp_type;

   // context carried alongside the divider
   typedef struct packed {
      logic signed [24:0] tf;
      logic [1:0]         status;
   } side_type;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_SAMPLE = 2'd1;
   localparam logic [1:0] STATUS_ZERO_DIV  = 2'd2;

   localparam logic [1:0] REG_TEMP  = 2'd0;
   localparam logic [1:0] REG_PLOW  = 2'd1;
   localparam logic [1:0] REG_PHIGH = 2'd2;
   localparam logic [1:0] REG_P9    = 2'd3;

   localparam logic signed [26:0] T_OFFSET = 27'sd128000;
   localparam int                 DIV_BITS = 64;

endpackage

`default_nettype wire

// ===== hdl/barsc_divider.sv =====
`default_nettype none

// Unsigned 64 / 31 bit restoring divider, one quotient bit per stage.
module barsc_divider (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic [63:0]         dividend,
   input  wire logic [30:0]         divisor,
   input  wire logic                neg,
   input  wire barsc_pkg::side_type side,
   output logic                     out_valid,
   output logic [63:0]              quotient,
   output logic                     out_neg,
   output barsc_pkg::side_type      out_side
);

   localparam int N = barsc_pkg::DIV_BITS;

   logic                v_ff    [0:N];
   logic [63:0]         n_ff    [0:N];
   logic [30:0]         r_ff    [0:N];
   logic [30:0]         mb_ff   [0:N];
   logic                neg_ff  [0:N];
   barsc_pkg::side_type side_ff [0:N];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff[0]    <= dividend;
         r_ff[0]    <= '0;
         mb_ff[0]   <= divisor;
         neg_ff[0]  <= neg;
         side_ff[0] <= side;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_step
      logic [31:0] trial;
      logic [31:0] diff;
      logic        ge;

      assign trial = {r_ff[k], n_ff[k][63]};
      assign diff  = trial - {1'b0, mb_ff[k]};
      assign ge    = trial >= {1'b0, mb_ff[k]};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k+1]    <= {n_ff[k][62:0], ge};
            r_ff[k+1]    <= ge ? diff[30:0] : trial[30:0];
            mb_ff[k+1]   <= mb_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = v_ff[N];
   assign quotient  = n_ff[N];
   assign out_neg   = neg_ff[N];
   assign out_side  = side_ff[N];

endmodule

`default_nettype wire

// ===== hdl/barometric_sensor_compensation_core.sv =====
`default_nettype none

// Channel   Ports                          Direction  Transaction
// req       req_valid/ready, req_payload   in         raw temperature + pressure
// rsp       rsp_valid/ready, rsp_payload   out        tenths, pascals, status
// csr       csr_psel..csr_prdata           in/out     coefficient registers, 8*i
//
// One transaction per cycle sustained while the skid is empty; the path runs
// through 9 front stages, a 65-stage bit-per-stage divider, 6 back stages and the output reg.
// Synchronous active-high reset clears valid bits and coefficients to zero.
// The whole pipe advances on one enable; a skid register behind the output
// register absorbs the transaction in flight, so req_ready drops only when
// the skid is full.
module barometric_sensor_compensation_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire barsc_pkg::req_type req_payload,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output barsc_pkg::rsp_type      rsp_payload,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [4:0]         csr_paddr,
   input  wire logic [63:0]        csr_pwdata,
   output logic [63:0]             csr_prdata,
   output logic                    csr_pready
);

   // ---------------- coefficient registers ----------------
   logic [47:0] temp_ff;
   logic [63:0] plow_ff;
   logic [63:0] phigh_ff;
   logic [15:0] p9_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff  <= '0;
         plow_ff  <= '0;
         phigh_ff <= '0;
         p9_ff    <= '0;
      end else if (csr_wr) begin
         case (csr_paddr[4:3])
            barsc_pkg::REG_TEMP:  temp_ff  <= csr_pwdata[47:0];
            barsc_pkg::REG_PLOW:  plow_ff  <= csr_pwdata;
            barsc_pkg::REG_PHIGH: phigh_ff <= csr_pwdata;
            barsc_pkg::REG_P9:    p9_ff    <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:3])
         barsc_pkg::REG_TEMP:  csr_prdata = {16'd0, temp_ff};
         barsc_pkg::REG_PLOW:  csr_prdata = plow_ff;
         barsc_pkg::REG_PHIGH: csr_prdata = phigh_ff;
         barsc_pkg::REG_P9:    csr_prdata = {48'd0, p9_ff};
         default:              csr_prdata = '0;
      endcase
   end

   logic [15:0]        t1, p1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

   assign t1 = temp_ff[15:0];
   assign t2 = $signed(temp_ff[31:16]);
   assign t3 = $signed(temp_ff[47:32]);
   assign p1 = plow_ff[15:0];
   assign p2 = $signed(plow_ff[31:16]);
   assign p3 = $signed(plow_ff[47:32]);
   assign p4 = $signed(plow_ff[63:48]);
   assign p5 = $signed(phigh_ff[15:0]);
   assign p6 = $signed(phigh_ff[31:16]);
   assign p7 = $signed(phigh_ff[47:32]);
   assign p8 = $signed(phigh_ff[63:48]);
   assign p9 = $signed(p9_ff);

   // global advance; skid full is the only stall source
   logic en;
   logic skid_v_ff;

   assign en        = !skid_v_ff;
   assign req_ready = en;

   // ---------------- S1: temperature products ----------------
   logic signed [18:0] s1_diff1;
   logic signed [17:0] s1_d;
   logic signed [34:0] s1_ma_in, s1_dd_in;
   logic               s1_v_ff, s1_zero_ff;
   logic signed [34:0] s1_ma_ff, s1_dd_ff;
   logic [19:0]        s1_adcp_ff;

   assign s1_diff1 = $signed({2'b00, req_payload.raw_temperature[19:3]})
                   - $signed({2'b00, t1, 1'b0});
   assign s1_d     = $signed({2'b00, req_payload.raw_temperature[19:4]})
                   - $signed({2'b00, t1});
   assign s1_ma_in = s1_diff1 * t2;
   assign s1_dd_in = s1_d * s1_d;

   // ---------------- S2 ----------------
   logic signed [23:0] s2_at_in;
   logic signed [22:0] s2_dd12;
   logic signed [38:0] s2_pr_in;
   logic               s2_v_ff, s2_zero_ff;
   logic signed [23:0] s2_at_ff;
   logic signed [38:0] s2_pr_ff;
   logic [19:0]        s2_adcp_ff;

   assign s2_at_in = 24'(s1_ma_ff >>> 11);
   assign s2_dd12  = 23'(s1_dd_ff >>> 12);
   assign s2_pr_in = s2_dd12 * t3;

   // ---------------- S3: t_fine ----------------
   logic signed [24:0] s3_tf_in;
   logic signed [26:0] s3_av_in;
   logic               s3_v_ff, s3_zero_ff;
   logic signed [24:0] s3_tf_ff;
   logic signed [26:0] s3_av_ff;
   logic [19:0]        s3_adcp_ff;

   assign s3_tf_in = 25'(s2_at_ff) + 25'(s2_pr_ff >>> 14);
   assign s3_av_in = 27'(s3_tf_in) - barsc_pkg::T_OFFSET;

   // ---------------- S4: square and linear terms ----------------
   logic signed [53:0] s4_sq_in;
   logic signed [42:0] s4_ap5_in, s4_ap2_in;
   logic               s4_v_ff, s4_zero_ff;
   logic signed [53:0] s4_sq_ff;
   logic signed [42:0] s4_ap5_ff, s4_ap2_ff;
   logic signed [24:0] s4_tf_ff;
   logic [19:0]        s4_adcp_ff;

   assign s4_sq_in  = s3_av_ff * s3_av_ff;
   assign s4_ap5_in = s3_av_ff * p5;
   assign s4_ap2_in = s3_av_ff * p2;

   // ---------------- S5: split square times P6 / P3 ----------------
   logic signed [48:0] s5_l6_in, s5_l3_in;
   logic signed [37:0] s5_h6_full, s5_h3_full;
   logic [63:0]        s5_bpart_in, s5_ap2sh_in;
   logic               s5_v_ff, s5_zero_ff;
   logic signed [48:0] s5_l6_ff, s5_l3_ff;
   logic [31:0]        s5_h6_ff, s5_h3_ff;
   logic [63:0]        s5_bpart_ff, s5_ap2sh_ff;
   logic signed [24:0] s5_tf_ff;
   logic [19:0]        s5_adcp_ff;

   assign s5_l6_in    = $signed({1'b0, s4_sq_ff[31:0]}) * p6;
   assign s5_l3_in    = $signed({1'b0, s4_sq_ff[31:0]}) * p3;
   assign s5_h6_full  = $signed(s4_sq_ff[53:32]) * p6;
   assign s5_h3_full  = $signed(s4_sq_ff[53:32]) * p3;
   assign s5_bpart_in = ({{21{s4_ap5_ff[42]}}, s4_ap5_ff} << 17)
                      + ({{48{p4[15]}}, p4} << 35);
   assign s5_ap2sh_in = {{21{s4_ap2_ff[42]}}, s4_ap2_ff} << 12;

   // ---------------- S6: sums ----------------
   logic [63:0] s6_b_in, s6_a3, s6_a3s, s6_a1_in;
   logic [20:0] s6_padj_in;
   logic        s6_v_ff, s6_zero_ff;
   logic [63:0] s6_b_ff, s6_a1_ff;
   logic [20:0] s6_padj_ff;
   logic signed [24:0] s6_tf_ff;

   assign s6_b_in    = {{15{s5_l6_ff[48]}}, s5_l6_ff} + {s5_h6_ff, 32'd0} + s5_bpart_ff;
   assign s6_a3      = {{15{s5_l3_ff[48]}}, s5_l3_ff} + {s5_h3_ff, 32'd0};
   assign s6_a3s     = $signed(s6_a3) >>> 8;
   assign s6_a1_in   = s6_a3s + s5_ap2sh_ff;
   assign s6_padj_in = 21'd1048576 - {1'b0, s5_adcp_ff};

   // ---------------- S7: divisor base and numerator ----------------
   logic [63:0] s7_x_in, s7_n_in;
   logic        s7_v_ff, s7_zero_ff;
   logic [63:0] s7_x_ff, s7_n_ff;
   logic signed [24:0] s7_tf_ff;

   assign s7_x_in = 64'h0000_8000_0000_0000 + s6_a1_ff;
   assign s7_n_in = {12'd0, s6_padj_ff, 31'd0} - s6_b_ff;

   // ---------------- S8: times P1 and 3125, split ----------------
   logic [47:0] s8_xl_in;
   logic [31:0] s8_xh_in, s8_nh_in;
   logic [43:0] s8_nl_in;
   logic        s8_v_ff, s8_zero_ff;
   logic [47:0] s8_xl_ff;
   logic [31:0] s8_xh_ff, s8_nh_ff;
   logic [43:0] s8_nl_ff;
   logic signed [24:0] s8_tf_ff;

   assign s8_xl_in = s7_x_ff[31:0] * p1;
   assign s8_xh_in = s7_x_ff[63:32] * {16'd0, p1};
   assign s8_nl_in = s7_n_ff[31:0] * 12'd3125;
   assign s8_nh_in = s7_n_ff[63:32] * 32'd3125;

   // ---------------- S9: divisor and numerator ----------------
   logic [63:0] s9_xp, s9_num_in;
   logic        s9_v_ff, s9_zero_ff;
   logic [30:0] s9_dv_ff;
   logic [63:0] s9_num_ff;
   logic signed [24:0] s9_tf_ff;

   assign s9_xp     = {16'd0, s8_xl_ff} + {s8_xh_ff, 32'd0};
   assign s9_num_in = {20'd0, s8_nl_ff} + {s8_nh_ff, 32'd0};

   // ---------------- divider feed: magnitudes and status ----------------
   logic [63:0]         dv_ma;
   logic [30:0]         dv_mb;
   logic                dv_neg;
   barsc_pkg::side_type dv_side;

   assign dv_ma  = s9_num_ff[63] ? (64'd0 - s9_num_ff) : s9_num_ff;
   assign dv_mb  = s9_dv_ff[30] ? (31'd0 - s9_dv_ff) : s9_dv_ff;
   assign dv_neg = s9_num_ff[63] ^ s9_dv_ff[30];

   always_comb begin
      dv_side.tf = s9_tf_ff;
      if (s9_zero_ff) begin
         dv_side.status = barsc_pkg::STATUS_NO_SAMPLE;
      end else if (s9_dv_ff == 31'd0) begin
         dv_side.status = barsc_pkg::STATUS_ZERO_DIV;
      end else begin
         dv_side.status = barsc_pkg::STATUS_OK;
      end
   end

   logic                dq_v;
   logic [63:0]         dq_q;
   logic                dq_neg;
   barsc_pkg::side_type dq_side;

   barsc_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s9_v_ff),
      .dividend  (dv_ma),
      .divisor   (dv_mb),
      .neg       (dv_neg),
      .side      (dv_side),
      .out_valid (dq_v),
      .quotient  (dq_q),
      .out_neg   (dq_neg),
      .out_side  (dq_side)
   );

   // ---------------- D1: signed quotient ----------------
   logic [63:0]         d1_p_in;
   logic                d1_v_ff;
   logic [63:0]         d1_p_ff;
   barsc_pkg::side_type d1_side_ff;

   assign d1_p_in = dq_neg ? (64'd0 - dq_q) : dq_q;

   // ---------------- D2: (p>>13)^2 and p*P8 partials ----------------
   logic [63:0]        d2_x;
   logic [63:0]        d2_sqa_in;
   logic [31:0]        d2_sqb_in, d2_h8_in;
   logic signed [48:0] d2_l8_in;
   logic               d2_v_ff;
   logic [63:0]        d2_sqa_ff, d2_p_ff;
   logic [31:0]        d2_sqb_ff, d2_h8_ff;
   logic signed [48:0] d2_l8_ff;
   barsc_pkg::side_type d2_side_ff;

   assign d2_x      = $signed(d1_p_ff) >>> 13;
   assign d2_sqa_in = d2_x[31:0] * d2_x[31:0];
   assign d2_sqb_in = d2_x[31:0] * d2_x[63:32];
   assign d2_l8_in  = $signed({1'b0, d1_p_ff[31:0]}) * p8;
   assign d2_h8_in  = d1_p_ff[63:32] * {{16{p8[15]}}, p8};

   // ---------------- D3 ----------------
   logic [63:0] d3_sqx_in, d3_pp8, d3_b_in;
   logic        d3_v_ff;
   logic [63:0] d3_sqx_ff, d3_b_ff, d3_p_ff;
   barsc_pkg::side_type d3_side_ff;

   assign d3_sqx_in = d2_sqa_ff + {d2_sqb_ff[30:0], 33'd0};
   assign d3_pp8    = {{15{d2_l8_ff[48]}}, d2_l8_ff} + {d2_h8_ff, 32'd0};
   assign d3_b_in   = $signed(d3_pp8) >>> 19;

   // ---------------- D4: times P9, split ----------------
   logic signed [48:0] d4_l9_in;
   logic [31:0]        d4_h9_in;
   logic               d4_v_ff;
   logic signed [48:0] d4_l9_ff;
   logic [31:0]        d4_h9_ff;
   logic [63:0]        d4_b_ff, d4_p_ff;
   barsc_pkg::side_type d4_side_ff;

   assign d4_l9_in = $signed({1'b0, d3_sqx_ff[31:0]}) * p9;
   assign d4_h9_in = d3_sqx_ff[63:32] * {{16{p9[15]}}, p9};

   // ---------------- D5 ----------------
   logic [63:0] d5_pp9, d5_a9, d5_s_in;
   logic        d5_v_ff;
   logic [63:0] d5_s_ff;
   barsc_pkg::side_type d5_side_ff;

   assign d5_pp9  = {{15{d4_l9_ff[48]}}, d4_l9_ff} + {d4_h9_ff, 32'd0};
   assign d5_a9   = $signed(d5_pp9) >>> 25;
   assign d5_s_in = d4_p_ff + d5_a9 + d4_b_ff;

   // ---------------- D6: final shifts, saturation, error mux ----------------
   logic [63:0]        d6_sh, d6_pf, d6_pf8;
   logic [23:0]        d6_press;
   logic [24:0]        d6_tb;
   logic signed [24:0] d6_tq;
   logic signed [15:0] d6_temp;
   barsc_pkg::rsp_type d6_rsp_in;
   logic               d6_v_ff;
   barsc_pkg::rsp_type d6_rsp_ff;

   assign d6_sh  = $signed(d5_s_ff) >>> 8;
   assign d6_pf  = d6_sh + ({{48{p7[15]}}, p7} << 4);
   assign d6_pf8 = $signed(d6_pf) >>> 8;
   // divide by 512 toward zero: bias negatives before the shift
   assign d6_tb  = d5_side_ff.tf + (d5_side_ff.tf[24] ? 25'd511 : 25'd0);
   assign d6_tq  = $signed(d6_tb) >>> 9;

   always_comb begin
      if (d6_pf8[63]) begin
         d6_press = '0;
      end else if (|d6_pf8[62:24]) begin
         d6_press = 24'hFF_FFFF;
      end else begin
         d6_press = d6_pf8[23:0];
      end
      if (d6_tq > 25'sd32767) begin
         d6_temp = 16'sh7FFF;
      end else if (d6_tq < -25'sd32768) begin
         d6_temp = -16'sh8000;
      end else begin
         d6_temp = d6_tq[15:0];
      end
      d6_rsp_in.status = d5_side_ff.status;
      if (d5_side_ff.status == barsc_pkg::STATUS_OK) begin
         d6_rsp_in.temperature_tenths = d6_temp;
         d6_rsp_in.pressure_pa        = d6_press;
      end else begin
         d6_rsp_in.temperature_tenths = '0;
         d6_rsp_in.pressure_pa        = '0;
      end
   end

   // ---------------- valid chain ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
         s7_v_ff <= 1'b0;
         s8_v_ff <= 1'b0;
         s9_v_ff <= 1'b0;
         d1_v_ff <= 1'b0;
         d2_v_ff <= 1'b0;
         d3_v_ff <= 1'b0;
         d4_v_ff <= 1'b0;
         d5_v_ff <= 1'b0;
         d6_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
         s6_v_ff <= s5_v_ff;
         s7_v_ff <= s6_v_ff;
         s8_v_ff <= s7_v_ff;
         s9_v_ff <= s8_v_ff;
         d1_v_ff <= dq_v;
         d2_v_ff <= d1_v_ff;
         d3_v_ff <= d2_v_ff;
         d4_v_ff <= d3_v_ff;
         d5_v_ff <= d4_v_ff;
         d6_v_ff <= d5_v_ff;
      end
   end

   // ---------------- payload pipeline ----------------
   always_ff @(posedge clock) begin
      if (en) begin
         s1_ma_ff   <= s1_ma_in;
         s1_dd_ff   <= s1_dd_in;
         s1_adcp_ff <= req_payload.raw_pressure;
         s1_zero_ff <= req_payload.raw_pressure == 20'd0;

         s2_at_ff   <= s2_at_in;
         s2_pr_ff   <= s2_pr_in;
         s2_adcp_ff <= s1_adcp_ff;
         s2_zero_ff <= s1_zero_ff;

         s3_tf_ff   <= s3_tf_in;
         s3_av_ff   <= s3_av_in;
         s3_adcp_ff <= s2_adcp_ff;
         s3_zero_ff <= s2_zero_ff;

         s4_sq_ff   <= s4_sq_in;
         s4_ap5_ff  <= s4_ap5_in;
         s4_ap2_ff  <= s4_ap2_in;
         s4_tf_ff   <= s3_tf_ff;
         s4_adcp_ff <= s3_adcp_ff;
         s4_zero_ff <= s3_zero_ff;

         s5_l6_ff    <= s5_l6_in;
         s5_l3_ff    <= s5_l3_in;
         s5_h6_ff    <= s5_h6_full[31:0];
         s5_h3_ff    <= s5_h3_full[31:0];
         s5_bpart_ff <= s5_bpart_in;
         s5_ap2sh_ff <= s5_ap2sh_in;
         s5_tf_ff    <= s4_tf_ff;
         s5_adcp_ff  <= s4_adcp_ff;
         s5_zero_ff  <= s4_zero_ff;

         s6_b_ff    <= s6_b_in;
         s6_a1_ff   <= s6_a1_in;
         s6_padj_ff <= s6_padj_in;
         s6_tf_ff   <= s5_tf_ff;
         s6_zero_ff <= s5_zero_ff;

         s7_x_ff    <= s7_x_in;
         s7_n_ff    <= s7_n_in;
         s7_tf_ff   <= s6_tf_ff;
         s7_zero_ff <= s6_zero_ff;

         s8_xl_ff   <= s8_xl_in;
         s8_xh_ff   <= s8_xh_in;
         s8_nl_ff   <= s8_nl_in;
         s8_nh_ff   <= s8_nh_in;
         s8_tf_ff   <= s7_tf_ff;
         s8_zero_ff <= s7_zero_ff;

         s9_dv_ff   <= s9_xp[63:33];
         s9_num_ff  <= s9_num_in;
         s9_tf_ff   <= s8_tf_ff;
         s9_zero_ff <= s8_zero_ff;

         d1_p_ff    <= d1_p_in;
         d1_side_ff <= dq_side;

         d2_sqa_ff  <= d2_sqa_in;
         d2_sqb_ff  <= d2_sqb_in;
         d2_l8_ff   <= d2_l8_in;
         d2_h8_ff   <= d2_h8_in;
         d2_p_ff    <= d1_p_ff;
         d2_side_ff <= d1_side_ff;

         d3_sqx_ff  <= d3_sqx_in;
         d3_b_ff    <= d3_b_in;
         d3_p_ff    <= d2_p_ff;
         d3_side_ff <= d2_side_ff;

         d4_l9_ff   <= d4_l9_in;
         d4_h9_ff   <= d4_h9_in;
         d4_b_ff    <= d3_b_ff;
         d4_p_ff    <= d3_p_ff;
         d4_side_ff <= d3_side_ff;

         d5_s_ff    <= d5_s_in;
         d5_side_ff <= d4_side_ff;

         d6_rsp_ff  <= d6_rsp_in;
      end
   end

   // ---------------- output register with skid ----------------
   logic               out_v_ff;
   barsc_pkg::rsp_type out_ff, skid_ff;
   logic               take_out, arrive;

   assign take_out = !out_v_ff || rsp_ready;
   assign arrive   = en && d6_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (take_out) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end
      end else if (take_out) begin
         out_v_ff <= arrive;
      end else if (arrive) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (take_out) begin
            out_ff <= skid_ff;
         end
      end else if (take_out) begin
         out_ff <= d6_rsp_ff;
      end else if (arrive) begin
         skid_ff <= d6_rsp_ff;
      end
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_payload = out_ff;

`ifndef SYNTHESIS
   // skid holds a transaction only behind a full output register
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid valid with empty output register");

   // error results carry zero values
   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != barsc_pkg::STATUS_OK) |->
      (rsp_payload.temperature_tenths == 16'sd0) && (rsp_payload.pressure_pa == 24'd0))
      else $error("error status with nonzero values");

   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == barsc_pkg::STATUS_OK)
                 || (rsp_payload.status == barsc_pkg::STATUS_NO_SAMPLE)
                 || (rsp_payload.status == barsc_pkg::STATUS_ZERO_DIV))
      else $error("undefined status code");

   // a transaction arriving at a stalled output register that is not taken is captured in the skid
   a_skid_fill : assert property (@(posedge clock) disable iff (reset)
      !skid_v_ff && out_v_ff && !rsp_ready && d6_v_ff |=> skid_v_ff)
      else $error("arriving transaction not captured in skid");
`endif

endmodule

`default_nettype wire
